/* rtl/tws_pkg.sv */
// Package for the timing wheel scheduler: field types, operation codes and the
// command and status structs between the controller and the datapath.
// Depends on nothing; every other file of the block uses it.
package tws_pkg;

    localparam int OP_W         = 2;
    localparam int HANDLE_W     = 5;
    localparam int DELAY_W      = 8;
    localparam int COUNT_W      = 32;
    localparam int DELAY_MARGIN = 3;

    typedef logic [OP_W-1:0]     op_t;
    typedef logic [HANDLE_W-1:0] handle_t;
    typedef logic [DELAY_W-1:0]  delay_t;
    typedef logic [COUNT_W-1:0]  count_t;

    localparam op_t OP_ADD    = 2'd0;
    localparam op_t OP_REMOVE = 2'd1;
    localparam op_t OP_TICK   = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic latch_in;       // capture the accepted transaction
        logic rd_handle;      // read links and slot of the handle
        logic rd_unlink_slot; // read head and tail of the handle's slot
        logic do_unlink;      // write the unlink
        logic rd_app_tail;    // read tail of the target slot
        logic do_append;      // write the append
        logic rd_walk;        // read head and tail of the current slot
        logic emit_walk;      // emit the walked handle and fetch its successor
        logic walk_first;     // walked handle is the slot head
        logic phase;          // pass being walked
        logic emit_empty;     // emit the empty-slot result
        logic finish_tick;    // clear the slot, advance the wheel
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        op_t  op;
        logic handle_ok;
        logic pending;
        logic cur_nonempty;
        logic walk_at_tail;
    } dp_status_t;

endpackage

/* rtl/timing_wheel_scheduler.sv */
// Top level of the timing wheel scheduler: joins the controller and datapath.
// Depends on tws_pkg, tws_ctrl and tws_datapath.
//
// A transaction is taken when start is high while busy is low. An add of a
// handle that is not pending reads the target slot's tail, then appends; an
// add of a pending handle first reads the handle's links and slot, then the
// slot's head and tail, and unlinks before it appends, because every step of
// the unlink and append reads or writes a single-port link memory whose read
// data is registered. A remove of a pending handle runs the unlink steps. A
// tick fetches the slot's head and tail, then emits one handle per cycle in
// each of the two passes, set by the next-link fetch of the list walk; an
// empty slot gives the empty-slot result instead. Each result is shown for
// exactly one cycle with result_valid high, in the cycle after it is formed;
// the receiver cannot hold results off, so it must take every result as it
// appears. All results of one tick arrive in consecutive cycles, the last
// marked by last. No clearing pass is needed after reset.
module timing_wheel_scheduler #(
    parameter int SLOTS   = 16,
    parameter int HANDLES = 32
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  tws_pkg::op_t     operation,
    input  tws_pkg::handle_t handle_id,
    input  tws_pkg::delay_t  delay,
    output logic             result_valid,
    output tws_pkg::handle_t handle_id_res,
    output logic             phase,
    output logic             slot_empty,
    output logic             last,
    output tws_pkg::count_t  tick_count
);

    // Command and status groups between the two halves.
    tws_pkg::dp_cmd_t    cmd;
    tws_pkg::dp_status_t status;

    // The controller walks each transaction through its memory steps.
    tws_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .status (status),
        .cmd    (cmd)
    );

    // The datapath holds the wheel, the linked lists and the result registers.
    tws_datapath #(
        .SLOTS   (SLOTS),
        .HANDLES (HANDLES)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .operation     (operation),
        .handle_id     (handle_id),
        .delay         (delay),
        .result_valid  (result_valid),
        .handle_id_res (handle_id_res),
        .phase         (phase),
        .slot_empty    (slot_empty),
        .last          (last),
        .tick_count    (tick_count)
    );

    // A tick's results come in an unbroken run of cycles.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !last |=> result_valid)
        else $error("tick results are not contiguous");

    // Every result of one tick carries the same tick count.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !last |=> tick_count == $past(tick_count))
        else $error("tick count changed within a tick");

    // The empty-slot result stands alone in the declaration pass.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && slot_empty |-> last && !phase)
        else $error("malformed empty-slot result");

    // An accepted transaction keeps the block busy in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("accepted transaction did not raise busy");

endmodule

/* rtl/tws_datapath.sv */
// Datapath of the timing wheel scheduler: slot and link memories, pending and
// occupancy flags, wheel pointer, tick counter and result registers.
// Depends on tws_pkg.
module tws_datapath #(
    parameter int SLOTS   = 16,
    parameter int HANDLES = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  tws_pkg::dp_cmd_t     cmd,
    output tws_pkg::dp_status_t  status,
    input  tws_pkg::op_t         operation,
    input  tws_pkg::handle_t     handle_id,
    input  tws_pkg::delay_t      delay,
    output logic                 result_valid,
    output tws_pkg::handle_t     handle_id_res,
    output logic                 phase,
    output logic                 slot_empty,
    output logic                 last,
    output tws_pkg::count_t      tick_count
);

    localparam int SLOT_W = $clog2(SLOTS);
    localparam int HID_W  = $clog2(HANDLES);
    localparam tws_pkg::delay_t   DELAY_MAX  = tws_pkg::delay_t'(SLOTS - tws_pkg::DELAY_MARGIN);
    localparam logic [SLOT_W:0]   SLOT_COUNT = (SLOT_W + 1)'(SLOTS);
    localparam logic [SLOT_W-1:0] SLOT_LAST  = SLOT_W'(SLOTS - 1);

    tws_pkg::op_t        op_reg;
    logic [HID_W-1:0]    hid_reg;
    logic                hok_reg;
    logic [SLOT_W-1:0]   target_reg;
    logic [SLOT_W-1:0]   current_reg;
    tws_pkg::count_t     count_reg;
    logic [HANDLES-1:0]  pending_reg;
    logic [SLOTS-1:0]    nonempty_reg;

    logic [HID_W-1:0]    next_mem  [HANDLES];
    logic [HID_W-1:0]    prev_mem  [HANDLES];
    logic [SLOT_W-1:0]   hslot_mem [HANDLES];
    logic [HID_W-1:0]    head_mem  [SLOTS];
    logic [HID_W-1:0]    tail_mem  [SLOTS];

    logic [HID_W-1:0]    next_q;
    logic [HID_W-1:0]    prev_q;
    logic [SLOT_W-1:0]   hslot_q;
    logic [HID_W-1:0]    head_q;
    logic [HID_W-1:0]    tail_q;

    logic                result_valid_reg;
    tws_pkg::handle_t    res_hid_reg;
    logic                res_phase_reg;
    logic                res_empty_reg;
    logic                res_last_reg;
    tws_pkg::count_t     res_count_reg;

    tws_pkg::delay_t     delay_clamped;
    logic [SLOT_W:0]     slot_sum;
    logic [SLOT_W-1:0]   target_next;
    logic [SLOT_W-1:0]   current_next;
    logic [HID_W-1:0]    cur;
    logic                unl_head;
    logic                unl_tail;
    logic                unl_mid;
    logic                append_ne;
    logic                at_tail;

    always_comb
    begin
        delay_clamped = (delay > DELAY_MAX) ? DELAY_MAX : delay;
        slot_sum      = {1'b0, current_reg} + (SLOT_W + 1)'(delay_clamped);
        if (slot_sum >= SLOT_COUNT)
        begin
            target_next = SLOT_W'(slot_sum - SLOT_COUNT);
        end
        else
        begin
            target_next = slot_sum[SLOT_W-1:0];
        end
        current_next = (current_reg == SLOT_LAST) ? '0 : current_reg + 1'b1;
        cur          = cmd.walk_first ? head_q : next_q;
        at_tail      = (cur == tail_q);
        unl_head     = (head_q == hid_reg);
        unl_tail     = (tail_q == hid_reg);
        unl_mid      = !unl_head && !unl_tail;
        append_ne    = nonempty_reg[target_reg];
    end

    assign status.op           = op_reg;
    assign status.handle_ok    = hok_reg;
    assign status.pending      = hok_reg && pending_reg[hid_reg];
    assign status.cur_nonempty = nonempty_reg[current_reg];
    assign status.walk_at_tail = at_tail;

    // Captured transaction.
    always_ff @(posedge clk)
    begin
        if (cmd.latch_in)
        begin
            op_reg     <= operation;
            hid_reg    <= handle_id[HID_W-1:0];
            hok_reg    <= (int'(handle_id) < HANDLES);
            target_reg <= target_next;
        end
    end

    // Flags, wheel pointer and tick counter.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg  <= '0;
            nonempty_reg <= '0;
            current_reg  <= '0;
            count_reg    <= '0;
        end
        else
        begin
            if (cmd.do_unlink)
            begin
                pending_reg[hid_reg] <= 1'b0;
                if (unl_head && unl_tail)
                begin
                    nonempty_reg[hslot_q] <= 1'b0;
                end
            end
            if (cmd.do_append)
            begin
                pending_reg[hid_reg]     <= 1'b1;
                nonempty_reg[target_reg] <= 1'b1;
            end
            if (cmd.emit_walk && cmd.phase)
            begin
                pending_reg[cur] <= 1'b0;
            end
            if (cmd.finish_tick)
            begin
                nonempty_reg[current_reg] <= 1'b0;
                current_reg               <= current_next;
                count_reg                 <= count_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.do_unlink && unl_mid)
        begin
            next_mem[prev_q] <= next_q;
        end
        else if (cmd.do_append && append_ne)
        begin
            next_mem[tail_q] <= hid_reg;
        end
        if (cmd.rd_handle)
        begin
            next_q <= next_mem[hid_reg];
        end
        else if (cmd.emit_walk)
        begin
            next_q <= next_mem[cur];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.do_unlink && unl_mid)
        begin
            prev_mem[next_q] <= prev_q;
        end
        else if (cmd.do_append)
        begin
            prev_mem[hid_reg] <= append_ne ? tail_q : hid_reg;
        end
        if (cmd.rd_handle)
        begin
            prev_q <= prev_mem[hid_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.do_append)
        begin
            hslot_mem[hid_reg] <= target_reg;
        end
        if (cmd.rd_handle)
        begin
            hslot_q <= hslot_mem[hid_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.do_unlink && unl_head && !unl_tail)
        begin
            head_mem[hslot_q] <= next_q;
        end
        else if (cmd.do_append && !append_ne)
        begin
            head_mem[target_reg] <= hid_reg;
        end
        if (cmd.rd_unlink_slot)
        begin
            head_q <= head_mem[hslot_q];
        end
        else if (cmd.rd_walk)
        begin
            head_q <= head_mem[current_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.do_unlink && unl_tail && !unl_head)
        begin
            tail_mem[hslot_q] <= prev_q;
        end
        else if (cmd.do_append)
        begin
            tail_mem[target_reg] <= hid_reg;
        end
        if (cmd.rd_unlink_slot)
        begin
            tail_q <= tail_mem[hslot_q];
        end
        else if (cmd.rd_app_tail)
        begin
            tail_q <= tail_mem[target_reg];
        end
        else if (cmd.rd_walk)
        begin
            tail_q <= tail_mem[current_reg];
        end
    end

    // Result registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= cmd.emit_empty || cmd.emit_walk;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit_empty)
        begin
            res_hid_reg   <= '0;
            res_phase_reg <= 1'b0;
            res_empty_reg <= 1'b1;
            res_last_reg  <= 1'b1;
            res_count_reg <= count_reg;
        end
        else if (cmd.emit_walk)
        begin
            res_hid_reg   <= tws_pkg::handle_t'(cur);
            res_phase_reg <= cmd.phase;
            res_empty_reg <= 1'b0;
            res_last_reg  <= cmd.phase && at_tail;
            res_count_reg <= count_reg;
        end
    end

    assign result_valid  = result_valid_reg;
    assign handle_id_res = res_hid_reg;
    assign phase         = res_phase_reg;
    assign slot_empty    = res_empty_reg;
    assign last          = res_last_reg;
    assign tick_count    = res_count_reg;

endmodule

/* rtl/tws_ctrl.sv */
// Controller of the timing wheel scheduler: sequences add, remove and tick
// transactions over the datapath's single-port memories.
// Depends on tws_pkg.
module tws_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  tws_pkg::dp_status_t status,
    output tws_pkg::dp_cmd_t    cmd
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_DECODE = 3'd1;
    localparam logic [2:0] ST_UNL1   = 3'd2;
    localparam logic [2:0] ST_UNL2   = 3'd3;
    localparam logic [2:0] ST_APP0   = 3'd4;
    localparam logic [2:0] ST_APP1   = 3'd5;
    localparam logic [2:0] ST_WALK   = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       phase_reg;
    logic       phase_next;
    logic       first_reg;
    logic       first_next;

    always_comb
    begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        first_next     = first_reg;
        cmd            = '0;
        cmd.walk_first = first_reg;
        cmd.phase      = phase_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.latch_in = 1'b1;
                    state_next   = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                state_next = ST_IDLE;
                if (status.op == tws_pkg::OP_TICK)
                begin
                    if (status.cur_nonempty)
                    begin
                        cmd.rd_walk = 1'b1;
                        phase_next  = 1'b0;
                        first_next  = 1'b1;
                        state_next  = ST_WALK;
                    end
                    else
                    begin
                        cmd.emit_empty  = 1'b1;
                        cmd.finish_tick = 1'b1;
                    end
                end
                else if ((status.op == tws_pkg::OP_ADD || status.op == tws_pkg::OP_REMOVE)
                         && status.handle_ok)
                begin
                    if (status.pending)
                    begin
                        cmd.rd_handle = 1'b1;
                        state_next    = ST_UNL1;
                    end
                    else if (status.op == tws_pkg::OP_ADD)
                    begin
                        cmd.rd_app_tail = 1'b1;
                        state_next      = ST_APP1;
                    end
                end
            end
            ST_UNL1:
            begin
                cmd.rd_unlink_slot = 1'b1;
                state_next         = ST_UNL2;
            end
            ST_UNL2:
            begin
                cmd.do_unlink = 1'b1;
                state_next    = (status.op == tws_pkg::OP_ADD) ? ST_APP0 : ST_IDLE;
            end
            ST_APP0:
            begin
                cmd.rd_app_tail = 1'b1;
                state_next      = ST_APP1;
            end
            ST_APP1:
            begin
                cmd.do_append = 1'b1;
                state_next    = ST_IDLE;
            end
            ST_WALK:
            begin
                cmd.emit_walk = 1'b1;
                first_next    = 1'b0;
                if (status.walk_at_tail)
                begin
                    if (!phase_reg)
                    begin
                        phase_next = 1'b1;
                        first_next = 1'b1;
                    end
                    else
                    begin
                        cmd.finish_tick = 1'b1;
                        state_next      = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            phase_reg <= 1'b0;
            first_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            first_reg <= first_next;
        end
    end

    assign busy = (state_reg != ST_IDLE);

endmodule

/* test/tb.sv */
// Self-checking testbench for the timing wheel scheduler (top level timing_wheel_scheduler).
// Depends on tws_pkg and the RTL. It predicts every tick's results from its own copy of the
// wheel and checks each result against the oldest expected one.
module tb;

    timeunit 1ns;
    timeprecision 1ps;

    import tws_pkg::*;

    localparam int SLOTS          = 16;
    localparam int HANDLES        = 32;
    localparam int SLOT_W         = $clog2(SLOTS);
    localparam int MAX_DELAY      = SLOTS - DELAY_MARGIN;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int SETTLE_CYCLES  = 10;

    // The package names only the three real operations; the fourth code must be ignored.
    localparam op_t OP_UNUSED = 2'd3;

    typedef logic [SLOT_W-1:0] slot_t;

    // One result of a tick as the block should present it.
    typedef struct {
        handle_t handle;
        logic    phase;
        logic    empty;
        logic    last;
        count_t  count;
    } run_result_t;

    logic    clk = 1'b0;
    logic    rst_n;
    logic    start;
    logic    busy;
    op_t     operation;
    handle_t handle_id;
    delay_t  delay;
    logic    result_valid;
    handle_t handle_id_res;
    logic    phase;
    logic    slot_empty;
    logic    last;
    count_t  tick_count;

    timing_wheel_scheduler #(
        .SLOTS   (SLOTS),
        .HANDLES (HANDLES)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .operation     (operation),
        .handle_id     (handle_id),
        .delay         (delay),
        .result_valid  (result_valid),
        .handle_id_res (handle_id_res),
        .phase         (phase),
        .slot_empty    (slot_empty),
        .last          (last),
        .tick_count    (tick_count)
    );

    always #2 clk = ~clk;

    // ------------------------------------------------------------------
    // Predicted wheel. Each bucket is a doubly linked list over the handle
    // pool, kept exactly as the block keeps it, stale links included, so
    // that the walk order of every tick can be worked out.
    // ------------------------------------------------------------------
    slot_t   wheel_slot                = '0;
    count_t  wheel_ticks               = '0;
    handle_t bucket_head   [SLOTS]     = '{default: '0};
    handle_t bucket_tail   [SLOTS]     = '{default: '0};
    logic    bucket_used   [SLOTS]     = '{default: 1'b0};
    handle_t link_next     [HANDLES]   = '{default: '0};
    handle_t link_prev     [HANDLES]   = '{default: '0};
    logic    handle_armed  [HANDLES]   = '{default: 1'b0};
    slot_t   handle_bucket [HANDLES]   = '{default: '0};

    run_result_t expected_runs[$];
    run_result_t oldest_run;
    int          mismatch_count = 0;
    int          idle_cycles    = 0;
    int          sender_idle_pct = 0;

    // Takes a pending handle out of its bucket. Only the head and tail of the
    // bucket are fixed when the handle sits at an end; the neighbour's link
    // is left stale, which is harmless because walks stop at the tail.
    function automatic void detach_handle(handle_t h);
        slot_t   s;
        handle_t p;
        handle_t n;
        logic    at_head;
        logic    at_tail;
        s       = handle_bucket[h];
        p       = link_prev[h];
        n       = link_next[h];
        at_head = (bucket_head[s] == h);
        at_tail = (bucket_tail[s] == h);
        if (at_head && at_tail)
        begin
            bucket_used[s] = 1'b0;
            bucket_head[s] = '0;
            bucket_tail[s] = '0;
        end
        else if (at_head)
        begin
            bucket_head[s] = n;
        end
        else if (at_tail)
        begin
            bucket_tail[s] = p;
        end
        else
        begin
            link_next[p] = n;
            link_prev[n] = p;
        end
        handle_armed[h] = 1'b0;
    endfunction

    // Appends a handle at the tail of a bucket, so arrival order is kept.
    function automatic void attach_handle(handle_t h, slot_t s);
        handle_t t;
        if (bucket_used[s])
        begin
            t            = bucket_tail[s];
            link_next[t] = h;
            link_prev[h] = t;
        end
        else
        begin
            bucket_head[s] = h;
            link_prev[h]   = h;
            bucket_used[s] = 1'b1;
        end
        link_next[h]     = h;
        bucket_tail[s]   = h;
        handle_bucket[h] = s;
        handle_armed[h]  = 1'b1;
    endfunction

    // Updates the predicted wheel for one accepted transaction and queues the
    // results that a tick is due to produce.
    function automatic void predict_transaction(op_t op, handle_t h, delay_t d);
        handle_t     walk_order[HANDLES];
        handle_t     cur;
        int          walked;
        int          eff_delay;
        slot_t       s;
        run_result_t r;
        walked = 0;
        case (op)
            OP_ADD, OP_REMOVE:
            begin
                // An add of a handle that is already pending moves it, so the
                // old link is always undone first.
                if (handle_armed[h])
                    detach_handle(h);
                if (op == OP_ADD)
                begin
                    eff_delay = (int'(d) > MAX_DELAY) ? MAX_DELAY : int'(d);
                    attach_handle(h, slot_t'((int'(wheel_slot) + eff_delay) % SLOTS));
                end
            end
            OP_TICK:
            begin
                s = wheel_slot;
                if (bucket_used[s])
                begin
                    cur = bucket_head[s];
                    while (walked < HANDLES)
                    begin
                        walk_order[walked] = cur;
                        walked++;
                        if (cur == bucket_tail[s])
                            break;
                        cur = link_next[cur];
                    end
                end
                r.count = wheel_ticks;
                if (walked == 0)
                begin
                    // An empty bucket still answers the tick with one result.
                    r.handle = '0;
                    r.phase  = 1'b0;
                    r.empty  = 1'b1;
                    r.last   = 1'b1;
                    expected_runs.push_back(r);
                end
                else
                begin
                    r.empty = 1'b0;
                    for (int p = 0; p < 2; p++)
                    begin
                        for (int i = 0; i < walked; i++)
                        begin
                            r.handle = walk_order[i];
                            r.phase  = p[0];
                            r.last   = (p == 1) && (i == walked - 1);
                            expected_runs.push_back(r);
                        end
                    end
                    for (int i = 0; i < walked; i++)
                        handle_armed[walk_order[i]] = 1'b0;
                end
                bucket_used[s] = 1'b0;
                bucket_head[s] = '0;
                bucket_tail[s] = '0;
                wheel_slot     = slot_t'((int'(s) + 1) % SLOTS);
                wheel_ticks    = wheel_ticks + 1'b1;
            end
            default:
            begin
                // The unused operation code changes nothing.
            end
        endcase
    endfunction

    task automatic report_mismatch(input string what);
        $display("[%0t] MISMATCH: %s", $realtime, what);
        mismatch_count++;
    endtask

    // Sends one transaction. It is called just after a rising edge and
    // returns just after the edge that accepted the transaction, with start
    // still high, so back-to-back transactions need no extra cycle. Before
    // the transaction the sender may first drop start and go idle.
    task automatic send_transaction(input op_t op, input handle_t h, input delay_t d);
        if (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        start     <= 1'b1;
        operation <= op;
        handle_id <= h;
        delay     <= d;
        // busy read here still holds its value from before the edge.
        do
            @(posedge clk);
        while (busy);
        predict_transaction(op, h, d);
    endtask

    // Stops sending and waits until every expected result has arrived, then
    // lets the block finish any add or remove that produces no result.
    task automatic wait_for_drain();
        start <= 1'b0;
        @(posedge clk);
        while (expected_runs.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Hand-picked transactions: extremes of every field, every operation,
    // unlinking from the head, middle and tail of a list, re-adding a pending
    // handle, removing an idle handle, the unused operation code and ticks
    // over empty buckets.
    task automatic test_directed();
        sender_idle_pct = 0;
        send_transaction(OP_TICK, 5'd0, 8'd0);       // empty bucket, tick count zero
        send_transaction(OP_ADD, 5'd0, 8'd0);        // bucket 1
        send_transaction(OP_ADD, 5'd31, 8'd255);     // delay clamped, bucket 14
        send_transaction(OP_ADD, 5'd7, 8'd0);
        send_transaction(OP_ADD, 5'd9, 8'd0);
        send_transaction(OP_ADD, 5'd12, 8'd0);       // bucket 1 holds 0, 7, 9, 12
        send_transaction(OP_REMOVE, 5'd7, 8'd0);     // unlink from the middle
        send_transaction(OP_REMOVE, 5'd12, 8'd255);  // unlink the tail
        send_transaction(OP_ADD, 5'd0, 8'd0);        // pending head moves to the tail
        send_transaction(OP_REMOVE, 5'd20, 8'd0);    // not pending: nothing happens
        send_transaction(OP_UNUSED, 5'd21, 8'd170);  // ignored
        send_transaction(OP_ADD, 5'd3, 8'd1);        // bucket 2
        send_transaction(OP_ADD, 5'd3, 8'd1);        // re-add of a lone handle
        send_transaction(OP_TICK, 5'd31, 8'd255);    // runs 9 then 0 in both passes
        send_transaction(OP_TICK, 5'd0, 8'd0);       // runs 3
        send_transaction(OP_ADD, 5'd31, 8'd12);      // moves 31 from bucket 14 to 15
        send_transaction(OP_REMOVE, 5'd0, 8'd0);     // already run, so not pending
        send_transaction(OP_ADD, 5'd16, 8'd13);      // bucket 3 + 13 = 0 after wrap
        send_transaction(OP_TICK, 5'd0, 8'd0);       // empty bucket 3
        send_transaction(OP_UNUSED, 5'd10, 8'd85);
        wait_for_drain();
    endtask

    // Fills one bucket with the whole handle pool in a scrambled order and
    // ticks the wheel round to it, giving the longest tick there is.
    task automatic test_full_bucket();
        handle_t mask;
        mask = handle_t'($urandom_range(0, HANDLES - 1));
        sender_idle_pct = 10;
        for (int i = 0; i < HANDLES; i++)
            send_transaction(OP_ADD, handle_t'(i) ^ mask, delay_t'(MAX_DELAY));
        for (int i = 0; i <= MAX_DELAY; i++)
            send_transaction(OP_TICK, handle_t'($urandom), delay_t'($urandom));
        wait_for_drain();
    endtask

    // Random traffic. Adds dominate so that buckets build up lists of several
    // handles; removes and re-adds then hit every position in those lists.
    task automatic test_random_traffic(input int items, input int idle_pct);
        int      pick;
        op_t     op;
        delay_t  d;
        sender_idle_pct = idle_pct;
        for (int i = 0; i < items; i++)
        begin
            pick = $urandom_range(99);
            if (pick < 42)
                op = OP_ADD;
            else if (pick < 62)
                op = OP_REMOVE;
            else if (pick < 95)
                op = OP_TICK;
            else
                op = OP_UNUSED;
            if ($urandom_range(99) < 80)
                d = delay_t'($urandom_range(0, SLOTS - 1));
            else
                d = delay_t'($urandom_range(0, 255));
            send_transaction(op, handle_t'($urandom_range(0, HANDLES - 1)), d);
        end
    endtask

    // Every result is compared, field by field, with the oldest expectation.
    // Values read at the edge are those from before it, so no race arises.
    always @(posedge clk)
    begin
        if (rst_n && result_valid)
        begin
            if (expected_runs.size() == 0)
            begin
                report_mismatch($sformatf("result with none expected: handle %0d tick %0d",
                                          handle_id_res, tick_count));
            end
            else
            begin
                oldest_run = expected_runs.pop_front();
                if (handle_id_res !== oldest_run.handle)
                    report_mismatch($sformatf("handle_id_res %0d, want %0d (tick %0d)",
                                              handle_id_res, oldest_run.handle,
                                              oldest_run.count));
                if (phase !== oldest_run.phase)
                    report_mismatch($sformatf("phase %0b, want %0b (tick %0d)",
                                              phase, oldest_run.phase, oldest_run.count));
                if (slot_empty !== oldest_run.empty)
                    report_mismatch($sformatf("slot_empty %0b, want %0b (tick %0d)",
                                              slot_empty, oldest_run.empty, oldest_run.count));
                if (last !== oldest_run.last)
                    report_mismatch($sformatf("last %0b, want %0b (tick %0d)",
                                              last, oldest_run.last, oldest_run.count));
                if (tick_count !== oldest_run.count)
                    report_mismatch($sformatf("tick_count %0d, want %0d",
                                              tick_count, oldest_run.count));
            end
        end
    end

    // The watchdog ends the run if neither a transaction nor a result has
    // been seen for too long; the longest tick and the longest idle gap are
    // both far shorter than the limit.
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || result_valid)
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("[%0t] watchdog expired with %0d results outstanding",
                         $realtime, expected_runs.size());
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n     <= 1'b0;
        start     <= 1'b0;
        operation <= OP_ADD;
        handle_id <= '0;
        delay     <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_full_bucket();
        // Idling phases: none, heavy sender gaps, light sender gaps, none.
        test_random_traffic(80, 0);
        wait_for_drain();
        test_random_traffic(80, 45);
        test_random_traffic(80, 10);
        wait_for_drain();
        test_random_traffic(68, 0);

        // The final drain also covers the trailing cycles of a silent add.
        wait_for_drain();
        if (mismatch_count == 0)
        begin
            $display("end of test: clean");
        end
        else
        begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
